// ===== design/mfbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbp_pkg
// Shared types and constants for the MSB-first bit packer.
// ----------------------------------------------------------------------------
package mfbp_pkg;

  // Default sizing
  localparam int MAX_BYTES_DEF   = 64;
  localparam int SLACK_BYTES_DEF = 4;

  // Field geometry
  localparam int FIELD_BITS = 32;               // widest appended field
  localparam int WIN_W      = FIELD_BITS + 8;   // field plus worst-case bit offset
  localparam int SPAN_W     = 3;                // holds up to 5 bytes touched
  localparam int CAP_W      = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Port field widths
  localparam int OP_W     = 2;
  localparam int COUNT_W  = 6;
  localparam int INDEX_W  = 7;
  localparam int RDB_W    = 8;
  localparam int REM_W    = 10;
  localparam int USED_W   = 7;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2,
    OP_STATUS = 2'd3
  } op_t;

  // Controller -> datapath
  typedef struct packed {
    logic item_load;
    logic exec;
    logic mem_write;
    logic rd_capture;
    logic out_load;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    op_t  op;
    logic app_go;
    logic last_byte;
    logic out_free;
  } sts_t;

endpackage

// ===== design/mfbp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mfbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 68
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/mfbp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbp_ctrl
// Sequencer: accepts one item, steps the datapath, hands off the result.
// ----------------------------------------------------------------------------
module mfbp_ctrl
  import mfbp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_WRITE  = 5'b00100,
    ST_RDWAIT = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // no transfer is taken while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.item_load = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.app_go) begin
          state_nxt = ST_WRITE;
        end else if (sts.op == OP_READ) begin
          state_nxt = ST_RDWAIT;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_WRITE: begin
        cmd.mem_write = 1'b1;
        if (sts.last_byte) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RDWAIT: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/mfbp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbp_dp
// Datapath: cursor, capacity, field alignment, byte store and result register.
// ----------------------------------------------------------------------------
module mfbp_dp
  import mfbp_pkg::*;
#(
  parameter int MAX_BYTES   = MAX_BYTES_DEF,
  parameter int SLACK_BYTES = SLACK_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CAP_W-1:0]      cfg_wr_data,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  localparam int STORE = MAX_BYTES + SLACK_BYTES;
  localparam int CUR_W = $clog2(STORE * 8 + 1);
  localparam int SUM_W = CUR_W + 1;
  localparam int IDX_W = $clog2(STORE);

  // Item registers
  op_t                    op_r;
  logic [FIELD_BITS-1:0]  data_r;
  logic [COUNT_W-1:0]     count_r;
  logic [INDEX_W-1:0]     index_r;

  // Architectural state
  logic [CAP_W-1:0]       cap_r;
  logic [CUR_W-1:0]       cursor_r;

  // Append sequencing
  logic [WIN_W-1:0]       win_r;
  logic [IDX_W-1:0]       waddr_r;
  logic [SPAN_W-1:0]      left_r;
  logic                   first_r;
  logic                   off_nz_r;

  // Result registers
  logic [RDB_W-1:0]       rd_byte_r;
  logic                   err_r;
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;

  // Combinational
  logic [CAP_W-1:0]       eff_cap;
  logic [COUNT_W-1:0]     cnt;
  logic [2:0]             off;
  logic [SUM_W-1:0]       sum;
  logic [SUM_W-1:0]       limit;
  logic [SUM_W-1:0]       cap_bits;
  logic [SUM_W-1:0]       cur_x;
  logic [SUM_W-1:0]       used_full;
  logic [SUM_W-1:0]       remain;
  logic                   is_app;
  logic                   app_go;
  logic                   app_err;
  logic [FIELD_BITS-1:0]  field_val;
  logic [5:0]             sh;
  logic [WIN_W-1:0]       win;
  logic [SPAN_W-1:0]      nbytes;
  logic [IDX_W-1:0]       rd_addr;
  logic [RDB_W-1:0]       rd_data;
  logic [RDB_W-1:0]       wr_data;

  // Capacity clamp and counts
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CAP_W'(1);
    end else if (32'(cap_r) > MAX_BYTES) begin
      eff_cap = CAP_W'(MAX_BYTES);
    end else begin
      eff_cap = cap_r;
    end
  end

  assign cnt       = (count_r > COUNT_W'(FIELD_BITS)) ? COUNT_W'(FIELD_BITS) : count_r;
  assign off       = cursor_r[2:0];
  assign cur_x     = SUM_W'(cursor_r);
  assign sum       = cur_x + SUM_W'(cnt);
  assign limit     = (SUM_W'(eff_cap) + SUM_W'(SLACK_BYTES)) << 3;
  assign cap_bits  = SUM_W'(eff_cap) << 3;
  assign used_full = (cur_x + SUM_W'(7)) >> 3;
  assign remain    = (cur_x < cap_bits) ? (cap_bits - cur_x) : '0;

  assign is_app  = (op_r == OP_APPEND) && (cnt != '0);
  assign app_go  = is_app && (sum <= limit);
  assign app_err = is_app && (sum > limit);

  // Field alignment: MSB of the field lands at bit (7 - off) of the cursor byte
  assign field_val = data_r & ({FIELD_BITS{1'b1}} >> (6'(FIELD_BITS) - cnt));
  assign sh        = 6'(WIN_W) - 6'(off) - cnt;
  assign win       = WIN_W'(field_val) << sh;
  assign nbytes    = SPAN_W'((7'(off) + 7'(cnt) + 7'd7) >> 3);

  // Store read address: the read index or the cursor byte
  assign rd_addr = (op_r == OP_READ) ? IDX_W'(index_r) : IDX_W'(cursor_r >> 3);

  // First byte merges with what is already there when the cursor is mid-byte
  assign wr_data = win_r[WIN_W-1 -: RDB_W] | ((first_r && off_nz_r) ? rd_data : '0);

  mfbp_ram #(
    .WIDTH (RDB_W),
    .DEPTH (STORE)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.mem_write),
    .wr_addr (waddr_r),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      op_r    <= op_t'(in_tuser);
      data_r  <= in_tdata[31:0];
      count_r <= in_tdata[37:32];
      index_r <= in_tdata[44:38];
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Cursor: bytes at or past the rounded-up cursor read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
    end else if (cmd.exec) begin
      if (op_r == OP_CLEAR) begin
        cursor_r <= '0;
      end else if (app_go) begin
        cursor_r <= CUR_W'(sum);
      end
    end
  end

  // Byte write sequencing
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      win_r    <= win;
      waddr_r  <= IDX_W'(cursor_r >> 3);
      left_r   <= nbytes;
      first_r  <= 1'b1;
      off_nz_r <= (off != '0);
    end else if (cmd.mem_write) begin
      win_r   <= win_r << RDB_W;
      waddr_r <= waddr_r + IDX_W'(1);
      left_r  <= left_r - SPAN_W'(1);
      first_r <= 1'b0;
    end
  end

  // Per-item result fields
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      err_r     <= app_err;
      rd_byte_r <= '0;
    end else if (cmd.rd_capture) begin
      rd_byte_r <= (32'(index_r) < 32'(used_full)) ? rd_data : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {4'b0000,
                     err_r,
                     (cur_x > cap_bits),
                     (cur_x >= cap_bits),
                     USED_W'(used_full),
                     REM_W'(remain),
                     rd_byte_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.op        = op_r;
  assign sts.app_go    = app_go;
  assign sts.last_byte = (left_r == SPAN_W'(1));
  assign sts.out_free  = !out_valid_r || out_tready;

endmodule

// ===== design/msb_first_bit_packer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_packer_top
// Packs variable-length bit fields MSB first into a byte store.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command per transfer. in_tuser carries the operation
//           (append, clear, read, status); in_tdata carries the field word,
//           its bit count and a byte index for reads.
//   out_* : exactly one status result per command, from an output register.
//   cfg_* : capacity in bytes, written while the block is idle.
// Timing:
//   One command at a time. Append of a field touching n bytes (1..5)
//   runs through execute, n byte writes and done, the byte writes going
//   one per cycle through the single write port of the store. Read adds
//   a wait state for the registered store read; clear, status and a
//   rejected or empty append go from execute straight to done. out_tvalid
//   rises once the done state finds the output register free and loads it.
// Reset:
//   Cursor is zero and capacity is 64; no clearing pass over the store is
//   needed since bytes beyond the cursor read as zero. in_tready is low
//   while reset is held.
// Stall:
//   A waiting result holds; the next command may be taken and runs until
//   its result is ready, then waits for the output register to free up.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_top
  import mfbp_pkg::*;
#(
  parameter int MAX_BYTES   = MAX_BYTES_DEF,
  parameter int SLACK_BYTES = SLACK_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] bit_data, [37:32] bit_count, [44:38] byte_index, [47:45] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] read_byte, [17:8] remaining_bits, [24:18] used_bytes,
  // [25] is_full, [26] is_overflow, [27] append_error, [31:28] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CAP_W-1:0]      cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  mfbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mfbp_dp #(
    .MAX_BYTES   (MAX_BYTES),
    .SLACK_BYTES (SLACK_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// ===== design/mfbp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbp_checker
// Port-level checks for the bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module mfbp_checker
  import mfbp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One command in flight: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous command busy");

  // Full exactly when no bits remain
  a_full_rem: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[17:8] == '0) == out_tdata[25]))
    else $error("is_full disagrees with remaining_bits");

  // Overflow implies full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[26] |-> out_tdata[25])
    else $error("is_overflow without is_full");

  // A rejected append returns no read data
  a_err_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[27] |-> (out_tdata[7:0] == '0))
    else $error("read_byte set on rejected append");

endmodule

bind msb_first_bit_packer_top mfbp_checker u_mfbp_checker (.*);

// ===== dv/msb_first_bit_packer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_packer_top_tb
// Self-checking bench for the MSB-first bit packer.
// A directed pass covers field extremes, every operation, zero and oversize
// bit counts, reads beyond the store, capacity codes out of range and a
// capacity shrunk under the cursor. Random traffic then runs in three phases
// with different idle patterns on both streams. A scoreboard class keeps its
// own byte store and cursor, predicts each status word and checks every
// result transfer field by field, in order.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_top_tb;
  import mfbp_pkg::*;

  localparam int STORE_BYTES    = MAX_BYTES_DEF + SLACK_BYTES_DEF;
  localparam int PHASE_ITEMS    = 180;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 2000;

  // status word, read_byte in the low bits
  typedef struct packed {
    logic              append_error;
    logic              is_overflow;
    logic              is_full;
    logic [USED_W-1:0] used_bytes;
    logic [REM_W-1:0]  remaining_bits;
    logic [RDB_W-1:0]  read_byte;
  } packer_status_t;

  // --------------------------------------------------------------------------
  // Scoreboard: bit packer predictor plus in-order status checker
  // --------------------------------------------------------------------------
  class bit_packer_sb;
    logic [7:0]       store_bytes [STORE_BYTES];
    int               bit_cursor;
    logic [CAP_W-1:0] capacity;
    bit               last_rejected;
    int               failures;
    packer_status_t   pending_status [$];

    function new();
      foreach (store_bytes[i]) store_bytes[i] = '0;
      bit_cursor    = 0;
      capacity      = CAP_RESET;
      last_rejected = 0;
      failures      = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function int pending();
      return pending_status.size();
    endfunction

    // Apply one accepted command to the model and queue the status it reports
    function void note_command(op_t op, logic [31:0] data, logic [COUNT_W-1:0] count,
                               logic [INDEX_W-1:0] idx);
      packer_status_t s;
      int eff_cap, nbits, limit_bits, cap_bits, pos, i;
      s = '0;
      eff_cap = (capacity == 0) ? 1 : (capacity > MAX_BYTES_DEF) ? MAX_BYTES_DEF : capacity;
      case (op)
        OP_APPEND: begin
          nbits = (count > FIELD_BITS) ? FIELD_BITS : count;
          limit_bits = (eff_cap + SLACK_BYTES_DEF) * 8;
          if (nbits != 0) begin
            if (bit_cursor + nbits > limit_bits) begin
              s.append_error = 1'b1;
            end else begin
              // MSB of the field lands first, at bit 7 - (cursor mod 8) of the cursor byte
              for (i = nbits - 1; i >= 0; i--) begin
                pos = bit_cursor / 8;
                if (pos < STORE_BYTES)
                  store_bytes[pos][7 - (bit_cursor % 8)] |= data[i];
                bit_cursor++;
              end
            end
          end
          last_rejected = s.append_error;
        end
        OP_CLEAR: begin
          foreach (store_bytes[j]) store_bytes[j] = '0;
          bit_cursor    = 0;
          last_rejected = 0;
        end
        OP_READ: begin
          if (idx < STORE_BYTES) s.read_byte = store_bytes[idx];
        end
        default: ;
      endcase
      cap_bits         = eff_cap * 8;
      s.remaining_bits = REM_W'((bit_cursor < cap_bits) ? (cap_bits - bit_cursor) : 0);
      s.used_bytes     = USED_W'((bit_cursor + 7) / 8);
      s.is_full        = (bit_cursor >= cap_bits);
      s.is_overflow    = (bit_cursor > cap_bits);
      pending_status.push_back(s);
    endfunction

    // Compare one result transfer with the oldest queued status
    function void check_result(logic [OUT_DATA_W-1:0] word);
      packer_status_t got, want;
      got = packer_status_t'(word[$bits(packer_status_t)-1:0]);
      if (pending_status.size() == 0) begin
        $error("unexpected result transfer: %h", word);
        failures++;
        return;
      end
      want = pending_status.pop_front();
      if (got.read_byte !== want.read_byte) begin
        $error("read_byte: expected %0d, got %0d", want.read_byte, got.read_byte);
        failures++;
      end
      if (got.remaining_bits !== want.remaining_bits) begin
        $error("remaining_bits: expected %0d, got %0d",
               want.remaining_bits, got.remaining_bits);
        failures++;
      end
      if (got.used_bytes !== want.used_bytes) begin
        $error("used_bytes: expected %0d, got %0d", want.used_bytes, got.used_bytes);
        failures++;
      end
      if (got.is_full !== want.is_full) begin
        $error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
        failures++;
      end
      if (got.is_overflow !== want.is_overflow) begin
        $error("is_overflow: expected %0d, got %0d", want.is_overflow, got.is_overflow);
        failures++;
      end
      if (got.append_error !== want.append_error) begin
        $error("append_error: expected %0d, got %0d",
               want.append_error, got.append_error);
        failures++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [31:0] bit_data, [37:32] bit_count, [44:38] byte_index
  logic [OP_W-1:0]       in_tuser;   // [1:0] operation
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [7:0] read_byte, [17:8] remaining_bits,
                                     // [24:18] used_bytes, [25] is_full,
                                     // [26] is_overflow, [27] append_error
  logic                  cfg_wr_en;
  logic [CAP_W-1:0]      cfg_wr_data;

  bit_packer_sb sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_req;
  int rx_hold_seen;
  int rx_hold_left;
  int quiet_cycles;

  msb_first_bit_packer_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    out_tready   = 1'b0;
    rx_hold_seen = 0;
    rx_hold_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != rx_hold_seen) begin
        rx_hold_seen = rx_hold_req;
        rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        out_tready = 1'b0;
        rx_hold_left--;
      end else begin
        out_tready = ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Result transfers go to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one command and hold it until the transfer
  task automatic issue_command(op_t op, logic [31:0] data, logic [COUNT_W-1:0] count,
                               logic [INDEX_W-1:0] idx);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {3'b000, idx, count, data};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(op, data, count, idx);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Capacity changes only with the block idle
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = cap;
    sb.set_capacity(cap);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Mostly appends that fill the store; clears become likely after a reject
  task automatic issue_random_command();
    int   pick, len_pick, top_idx;
    op_t  op;
    logic [COUNT_W-1:0] count;
    logic [INDEX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    if (pick < (sb.last_rejected ? 40 : 3)) op = OP_CLEAR;
    else if (pick < 70)                     op = OP_APPEND;
    else if (pick < 92)                     op = OP_READ;
    else                                    op = OP_STATUS;
    len_pick = $urandom_range(0, 19);
    if (len_pick == 0)      count = '0;
    else if (len_pick == 1) count = COUNT_W'($urandom_range(FIELD_BITS + 1, 63));
    else                    count = COUNT_W'($urandom_range(1, FIELD_BITS));
    top_idx = (sb.bit_cursor + 7) / 8 + 3;
    if (top_idx > STORE_BYTES - 1) top_idx = STORE_BYTES - 1;
    if ($urandom_range(0, 9) < 7) idx = INDEX_W'($urandom_range(0, top_idx));
    else                          idx = INDEX_W'($urandom_range(0, 127));
    issue_command(op, $urandom, count, idx);
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = OP_STATUS;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = CAP_RESET;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    rx_hold_req  = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset capacity, field extremes, zero and oversize counts
    issue_command(OP_STATUS, 32'h0, 6'd0, 7'd0);
    issue_command(OP_APPEND, $urandom, 6'd0, 7'd0);
    issue_command(OP_APPEND, 32'h1, 6'd1, 7'd0);
    issue_command(OP_APPEND, 32'hFFFF_FFFF, 6'd32, 7'd0);
    issue_command(OP_APPEND, 32'hA5A5_A5A5, 6'd63, 7'd0);
    issue_command(OP_APPEND, 32'h0, 6'd7, 7'd0);
    issue_command(OP_READ, 32'h0, 6'd0, 7'd0);
    issue_command(OP_READ, 32'h0, 6'd0, 7'd4);
    issue_command(OP_READ, 32'h0, 6'd0, 7'd67);
    issue_command(OP_READ, 32'hFFFF_FFFF, 6'd63, 7'd127);

    // Capacity shrunk under the cursor, then filled to the slack limit
    write_capacity(7'd1);
    issue_command(OP_STATUS, 32'h0, 6'd0, 7'd0);
    issue_command(OP_APPEND, 32'h1, 6'd1, 7'd0);
    issue_command(OP_READ, 32'h0, 6'd0, 7'd8);
    issue_command(OP_CLEAR, 32'h0, 6'd0, 7'd0);
    issue_command(OP_APPEND, 32'h0, 6'd32, 7'd0);
    issue_command(OP_APPEND, 32'hFF, 6'd8, 7'd0);
    issue_command(OP_APPEND, 32'h1, 6'd1, 7'd0);
    issue_command(OP_READ, 32'h0, 6'd0, 7'd4);

    // Capacity code zero acts as one byte, codes above MAX_BYTES_DEF as MAX_BYTES_DEF
    write_capacity(7'd0);
    issue_command(OP_STATUS, 32'h0, 6'd0, 7'd0);
    issue_command(OP_CLEAR, 32'h0, 6'd0, 7'd0);
    issue_command(OP_APPEND, $urandom, 6'd16, 7'd0);
    write_capacity(7'd127);
    issue_command(OP_STATUS, 32'h0, 6'd0, 7'd0);
    issue_command(OP_APPEND, 32'hFFFF_FFFF, 6'd32, 7'd0);
    issue_command(OP_READ, 32'h0, 6'd0, 7'd2);

    // Random phase 1: full capacity, receiver stalls often
    write_capacity(7'd64);
    tx_idle_pct = 18;
    rx_idle_pct = 55;
    repeat (PHASE_ITEMS) issue_random_command();

    // Random phase 2: small capacity, sender idles often, one full pause
    write_capacity(CAP_W'($urandom_range(1, 16)));
    tx_idle_pct = 55;
    rx_idle_pct = 18;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n == PHASE_ITEMS / 2) wait_results_drained();
      issue_random_command();
    end

    // Random phase 3: any capacity code, no idling, one long receiver hold
    write_capacity(CAP_W'($urandom_range(0, 127)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n == 40) rx_hold_req = rx_hold_req + 1;
      issue_random_command();
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
